// File: rtl/slm_pkg.sv
// ----------------------------------------------------------------------------
// slm_pkg
// Shared types and constants for the signal level meter: action and state
// codes, register indexes, calibration points, controller/datapath bundles.
// ----------------------------------------------------------------------------
`default_nettype none

package slm_pkg;

	// Input item action codes
	typedef enum logic [1:0] {
		ACT_RX   = 2'd0,
		ACT_TX   = 2'd1,
		ACT_TICK = 2'd2,
		ACT_NONE = 2'd3
	} action_t;

	// Display mode codes
	typedef enum logic [1:0] {
		DISP_INST = 2'd0,
		DISP_AVG  = 2'd1,
		DISP_PEAK = 2'd2,
		DISP_RSVD = 2'd3
	} disp_mode_t;

	// Readout kind codes
	typedef enum logic [1:0] {
		RK_NONE  = 2'd0,
		RK_SUNIT = 2'd1,
		RK_OVER  = 2'd2,
		RK_RSVD  = 2'd3
	} readout_kind_t;

	// Configuration register indexes
	localparam int CFG_IDX_W = 3;
	localparam int CFG_DATA_W = 16;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_DISPLAY_MODE   = 3'd0,
		CFG_PEAK_HOLD      = 3'd1,
		CFG_AVERAGE_COEF   = 3'd2,
		CFG_DB_ATTACK      = 3'd3,
		CFG_DB_DECAY       = 3'd4,
		CFG_POWER_ATTACK   = 3'd5,
		CFG_POWER_DECAY    = 3'd6,
		CFG_UNUSED         = 3'd7
	} cfg_index_t;

	// Register reset values
	localparam logic [1:0]  RST_DISPLAY_MODE = 2'd0;
	localparam logic [7:0]  RST_PEAK_HOLD    = 8'd45;
	localparam logic [15:0] RST_AVERAGE_COEF = 16'd19661;
	localparam logic [15:0] RST_DB_ATTACK    = 16'd21627;
	localparam logic [15:0] RST_DB_DECAY     = 16'd3604;
	localparam logic [15:0] RST_POWER_ATTACK = 16'd27034;
	localparam logic [15:0] RST_POWER_DECAY  = 16'd6179;

	typedef struct packed {
		logic [1:0]  display_mode;
		logic [7:0]  peak_hold_ticks;
		logic [15:0] average_coef;
		logic [15:0] db_attack_coef;
		logic [15:0] db_decay_coef;
		logic [15:0] power_attack_coef;
		logic [15:0] power_decay_coef;
	} cfg_t;

	// Fixed field widths
	localparam int RAW_W   = 8;
	localparam int PWR_W   = 11;
	localparam int DBF_W   = 11;
	localparam int COEF_W  = 16;
	localparam int SUNIT_W = 4;
	localparam int OVER_W  = 6;
	localparam int OVER_MAX = 60;
	localparam int SUNIT_MAX = 9;
	localparam int FLOOR_DB = -54;
	localparam int SUNIT_SPAN_DB = 6;

	// Calibration points: raw strength against whole dB relative to S9
	localparam int CAL_LEN = 14;
	localparam int CAL_RAW [CAL_LEN] = '{10, 24, 38, 47, 61, 70, 79, 84, 94, 103,
		118, 134, 147, 161};
	localparam int CAL_DB [CAL_LEN] = '{-48, -42, -36, -30, -24, -18, -12, -6, 0, 10,
		20, 30, 40, 50};

	// Upper point of the segment that holds a raw value (1 .. CAL_LEN-1)
	function automatic int cal_seg(input int raw);
		int seg;
		seg = CAL_LEN - 1;
		for (int i = CAL_LEN - 1; i >= 1; i--) begin
			if (raw <= CAL_RAW[i]) begin
				seg = i;
			end
		end
		return seg;
	endfunction

	// Controller states
	typedef enum logic [3:0] {
		ST_IDLE,
		ST_RX_LOAD,
		ST_AVG_MUL,
		ST_AVG_ADD,
		ST_TX_LOAD,
		ST_NDB_MUL,
		ST_NDB_ADD,
		ST_NPW_MUL,
		ST_NPW_ADD,
		ST_EMIT
	} state_t;

	// Controller to datapath commands
	typedef struct packed {
		logic load_item;
		logic rx_load;
		logic avg_mul;
		logic avg_add;
		logic tx_load;
		logic ndb_mul;
		logic ndb_add;
		logic npw_mul;
		logic npw_add;
		logic emit;
	} cmd_t;

	// Datapath to controller status
	typedef struct packed {
		logic out_free;
	} sts_t;

endpackage

`default_nettype wire

// File: rtl/slm_item_if.sv
// ----------------------------------------------------------------------------
// slm_item_if
// Input request channel: action, raw receiver level and forward power.
// ----------------------------------------------------------------------------
`default_nettype none

interface slm_item_if;
	logic        valid;
	logic        ready;
	logic [1:0]  action;
	logic [7:0]  raw_level;
	logic [10:0] forward_power;

	modport source (output valid, output action, output raw_level, output forward_power,
		input ready);
	modport sink (input valid, input action, input raw_level, input forward_power,
		output ready);
endinterface

`default_nettype wire

// File: rtl/slm_result_if.sv
// ----------------------------------------------------------------------------
// slm_result_if
// Result channel: meter readings, needles, peaks and readout.
// ----------------------------------------------------------------------------
`default_nettype none

interface slm_result_if;
	logic               valid;
	logic               ready;
	logic signed [10:0] display_db;
	logic signed [10:0] needle_db;
	logic signed [10:0] peak_db;
	logic [1:0]         readout_kind;
	logic [3:0]         s_unit;
	logic [5:0]         over_s9_db;
	logic [10:0]        needle_power;
	logic [10:0]        peak_power;
	logic               transmitting;

	modport source (output valid, output display_db, output needle_db, output peak_db,
		output readout_kind, output s_unit, output over_s9_db, output needle_power,
		output peak_power, output transmitting, input ready);
	modport sink (input valid, input display_db, input needle_db, input peak_db,
		input readout_kind, input s_unit, input over_s9_db, input needle_power,
		input peak_power, input transmitting, output ready);
endinterface

`default_nettype wire

// File: rtl/slm_cfg_if.sv
// ----------------------------------------------------------------------------
// slm_cfg_if
// Configuration write channel: register index and write data.
// ----------------------------------------------------------------------------
`default_nettype none

interface slm_cfg_if;
	logic        valid;
	logic        ready;
	logic [2:0]  index;
	logic [15:0] data;

	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// File: rtl/slm_cfg_regs.sv
// ----------------------------------------------------------------------------
// slm_cfg_regs
// Configuration register file; takes a write request every cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module slm_cfg_regs (
	input  wire logic     clk,
	input  wire logic     arst_n,
	slm_cfg_if.sink       wr,
	output slm_pkg::cfg_t cfg
);

	slm_pkg::cfg_t cfg_q;

	assign wr.ready = 1'b1;
	assign cfg = cfg_q;

	// Write the addressed register; drop writes beyond the list
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.display_mode      <= slm_pkg::RST_DISPLAY_MODE;
			cfg_q.peak_hold_ticks   <= slm_pkg::RST_PEAK_HOLD;
			cfg_q.average_coef      <= slm_pkg::RST_AVERAGE_COEF;
			cfg_q.db_attack_coef    <= slm_pkg::RST_DB_ATTACK;
			cfg_q.db_decay_coef     <= slm_pkg::RST_DB_DECAY;
			cfg_q.power_attack_coef <= slm_pkg::RST_POWER_ATTACK;
			cfg_q.power_decay_coef  <= slm_pkg::RST_POWER_DECAY;
		end else if (wr.valid) begin
			case (wr.index)
				slm_pkg::CFG_DISPLAY_MODE: cfg_q.display_mode      <= wr.data[1:0];
				slm_pkg::CFG_PEAK_HOLD:    cfg_q.peak_hold_ticks   <= wr.data[7:0];
				slm_pkg::CFG_AVERAGE_COEF: cfg_q.average_coef      <= wr.data;
				slm_pkg::CFG_DB_ATTACK:    cfg_q.db_attack_coef    <= wr.data;
				slm_pkg::CFG_DB_DECAY:     cfg_q.db_decay_coef     <= wr.data;
				slm_pkg::CFG_POWER_ATTACK: cfg_q.power_attack_coef <= wr.data;
				slm_pkg::CFG_POWER_DECAY:  cfg_q.power_decay_coef  <= wr.data;
				default: ;
			endcase
		end
	end

endmodule

`default_nettype wire

// File: rtl/slm_ctrl.sv
// ----------------------------------------------------------------------------
// slm_ctrl
// Sequencer: accepts one request, steps the datapath through the update for
// its action, then hands the result to the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module slm_ctrl (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       in_valid,
	input  wire logic [1:0] in_action,
	output logic            in_ready,
	input  slm_pkg::sts_t   sts,
	output slm_pkg::cmd_t   cmd
);

	slm_pkg::state_t state_q;
	slm_pkg::state_t state_nxt;

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= slm_pkg::ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	// Next state and commands
	always_comb begin
		state_nxt = state_q;
		cmd       = '0;
		in_ready  = 1'b0;
		case (state_q)
			slm_pkg::ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load_item = 1'b1;
					case (in_action)
						slm_pkg::ACT_RX:   state_nxt = slm_pkg::ST_RX_LOAD;
						slm_pkg::ACT_TX:   state_nxt = slm_pkg::ST_TX_LOAD;
						slm_pkg::ACT_TICK: state_nxt = slm_pkg::ST_NDB_MUL;
						default:           state_nxt = slm_pkg::ST_EMIT;
					endcase
				end
			end
			slm_pkg::ST_RX_LOAD: begin
				cmd.rx_load = 1'b1;
				state_nxt   = slm_pkg::ST_AVG_MUL;
			end
			slm_pkg::ST_AVG_MUL: begin
				cmd.avg_mul = 1'b1;
				state_nxt   = slm_pkg::ST_AVG_ADD;
			end
			slm_pkg::ST_AVG_ADD: begin
				cmd.avg_add = 1'b1;
				state_nxt   = slm_pkg::ST_EMIT;
			end
			slm_pkg::ST_TX_LOAD: begin
				cmd.tx_load = 1'b1;
				state_nxt   = slm_pkg::ST_EMIT;
			end
			slm_pkg::ST_NDB_MUL: begin
				cmd.ndb_mul = 1'b1;
				state_nxt   = slm_pkg::ST_NDB_ADD;
			end
			slm_pkg::ST_NDB_ADD: begin
				cmd.ndb_add = 1'b1;
				state_nxt   = slm_pkg::ST_NPW_MUL;
			end
			slm_pkg::ST_NPW_MUL: begin
				cmd.npw_mul = 1'b1;
				state_nxt   = slm_pkg::ST_NPW_ADD;
			end
			slm_pkg::ST_NPW_ADD: begin
				cmd.npw_add = 1'b1;
				state_nxt   = slm_pkg::ST_EMIT;
			end
			slm_pkg::ST_EMIT: begin
				// Hold until the output register can take the result
				if (sts.out_free) begin
					cmd.emit  = 1'b1;
					state_nxt = slm_pkg::ST_IDLE;
				end
			end
			default: state_nxt = slm_pkg::ST_IDLE;
		endcase
	end

	a_rx_then_avg: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.rx_load |=> cmd.avg_mul)
		else $error("receive load not followed by average multiply");

	a_ndb_then_npw: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.ndb_add |=> cmd.npw_mul)
		else $error("dB needle update not followed by power needle multiply");

	a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load_item |=> !in_ready)
		else $error("controller took a request but stayed idle");

endmodule

`default_nettype wire

// File: rtl/slm_datapath.sv
// ----------------------------------------------------------------------------
// slm_datapath
// Meter state, calibration lookup, shared smoothing multiplier with
// rounding adder, readout logic and the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module slm_datapath #(
	parameter int DB_FRAC_BITS = 4,
	parameter int AGE_BITS     = 8
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  slm_pkg::cmd_t           cmd,
	output slm_pkg::sts_t           sts,
	input  slm_pkg::cfg_t           cfg,
	input  wire logic [7:0]         raw_level,
	input  wire logic [10:0]        forward_power,
	output logic                    out_valid,
	input  wire logic               out_ready,
	output logic signed [10:0]      out_display_db,
	output logic signed [10:0]      out_needle_db,
	output logic signed [10:0]      out_peak_db,
	output logic [1:0]              out_readout_kind,
	output logic [3:0]              out_s_unit,
	output logic [5:0]              out_over_s9_db,
	output logic [10:0]             out_needle_power,
	output logic [10:0]             out_peak_power,
	output logic                    out_transmitting
);

	localparam int DBW    = 7 + DB_FRAC_BITS;
	localparam int DB_ONE = 1 << DB_FRAC_BITS;
	localparam int MW     = (DBW + 1 > slm_pkg::PWR_W + 1) ? DBW + 1 : slm_pkg::PWR_W + 1;
	localparam int PW     = MW + slm_pkg::COEF_W + 1;
	localparam int CW     = (AGE_BITS > 8) ? AGE_BITS : 8;
	localparam int WX     = (DBW > slm_pkg::DBF_W) ? DBW : slm_pkg::DBF_W;
	localparam logic signed [DBW-1:0] DB_FLOOR = DBW'(slm_pkg::FLOOR_DB * DB_ONE);
	localparam logic signed [DBW:0]   DB_HALF  = (DBW + 1)'(DB_ONE / 2);
	localparam logic signed [DBW:0]   FLOOR_OFS = (DBW + 1)'(-slm_pkg::FLOOR_DB * DB_ONE);
	localparam logic signed [DBW:0]   SUNIT_RND = (DBW + 1)'(slm_pkg::SUNIT_SPAN_DB * DB_ONE / 2);
	localparam logic signed [DBW:0]   OVER_LIM = (DBW + 1)'(slm_pkg::OVER_MAX);
	localparam logic [PW:0]           Q16_HALF = (PW + 1)'(32768);

	// Calibration lookup: one entry per raw value, built at elaboration
	logic signed [DBW-1:0] cal_rom [256];

	for (genvar g = 0; g < 256; g++) begin : g_cal
		localparam int SEG = slm_pkg::cal_seg(g);
		localparam int R0  = slm_pkg::CAL_RAW[SEG-1];
		localparam int R1  = slm_pkg::CAL_RAW[SEG];
		localparam int D0  = slm_pkg::CAL_DB[SEG-1];
		localparam int D1  = slm_pkg::CAL_DB[SEG];
		localparam int DEN = R1 - R0;
		localparam int NUM = (g - R0) * (D1 - D0) * DB_ONE;
		localparam int VAL = (g <= slm_pkg::CAL_RAW[0]) ? slm_pkg::CAL_DB[0] * DB_ONE :
			(g >= slm_pkg::CAL_RAW[slm_pkg::CAL_LEN-1]) ?
			slm_pkg::CAL_DB[slm_pkg::CAL_LEN-1] * DB_ONE :
			D0 * DB_ONE + (2 * NUM + DEN) / (2 * DEN);
		assign cal_rom[g] = DBW'(VAL);
	end

	// Item and meter state
	logic [7:0]            raw_q;
	logic [10:0]           fwd_q;
	logic signed [DBW-1:0] level_q;
	logic signed [DBW-1:0] avg_q;
	logic                  avg_started_q;
	logic                  have_reading_q;
	logic                  tx_q;
	logic signed [DBW-1:0] held_db_q;
	logic                  held_db_valid_q;
	logic [AGE_BITS-1:0]   held_db_age_q;
	logic signed [DBW-1:0] needle_db_q;
	logic [10:0]           fwd_power_q;
	logic [10:0]           held_pw_q;
	logic                  held_pw_valid_q;
	logic [AGE_BITS-1:0]   held_pw_age_q;
	logic [10:0]           needle_pw_q;
	logic signed [PW-1:0]  prod_q;
	logic                  out_valid_q;

	// Combinational terms
	logic signed [DBW-1:0] cal_level;
	logic signed [DBW-1:0] sel_db;
	logic signed [DBW-1:0] db_target;
	logic [10:0]           pw_target;
	logic signed [DBW:0]   avg_diff;
	logic signed [DBW:0]   ndb_diff;
	logic signed [11:0]    npw_diff;
	logic signed [MW-1:0]  mul_a;
	logic [15:0]           mul_coef;
	logic signed [PW-1:0]  prod;
	logic                  p_neg;
	logic [PW:0]           p_mag;
	logic [PW:0]           p_rnd;
	logic [MW-1:0]         rnd_mag;
	logic signed [MW-1:0]  rnd;
	logic signed [MW:0]    avg_sum;
	logic signed [MW:0]    ndb_sum;
	logic signed [MW:0]    npw_sum;
	logic                  db_age_over;
	logic                  pw_age_over;
	logic                  db_replace;
	logic                  pw_replace;
	logic signed [DBW:0]   disp_x;
	logic signed [DBW:0]   over_sum;
	logic signed [DBW:0]   over_w;
	logic signed [DBW:0]   sun_num;
	logic signed [DBW:0]   sun_q;
	logic [12:0]           sun_prod;
	logic [4:0]            sun_raw;
	logic [1:0]            kind;
	logic [3:0]            sun;
	logic [5:0]            over;
	logic signed [WX-1:0]  sel_x;
	logic signed [WX-1:0]  needle_x;
	logic signed [WX-1:0]  held_x;

	assign cal_level = cal_rom[raw_q];

	// Select the displayed reading
	always_comb begin
		case (cfg.display_mode)
			slm_pkg::DISP_AVG:  sel_db = avg_q;
			slm_pkg::DISP_PEAK: sel_db = held_db_q;
			default:            sel_db = level_q;
		endcase
	end

	assign db_target = have_reading_q ? sel_db : DB_FLOOR;
	assign pw_target = tx_q ? fwd_power_q : 11'd0;

	assign avg_diff = (DBW + 1)'(level_q) - (DBW + 1)'(avg_q);
	assign ndb_diff = (DBW + 1)'(db_target) - (DBW + 1)'(needle_db_q);
	assign npw_diff = $signed({1'b0, pw_target}) - $signed({1'b0, needle_pw_q});

	// Multiplier operand select
	always_comb begin
		if (cmd.avg_mul) begin
			mul_a    = MW'(avg_diff);
			mul_coef = cfg.average_coef;
		end else if (cmd.ndb_mul) begin
			mul_a    = MW'(ndb_diff);
			mul_coef = (db_target > needle_db_q) ? cfg.db_attack_coef : cfg.db_decay_coef;
		end else begin
			mul_a    = MW'(npw_diff);
			mul_coef = (pw_target > needle_pw_q) ? cfg.power_attack_coef
				: cfg.power_decay_coef;
		end
	end

	assign prod = PW'(mul_a) * PW'($signed({1'b0, mul_coef}));

	// Round the registered product to nearest, ties away from zero
	assign p_neg   = prod_q[PW-1];
	assign p_mag   = p_neg ? (PW + 1)'(-prod_q) : (PW + 1)'(prod_q);
	assign p_rnd   = (p_mag + Q16_HALF) >> 16;
	assign rnd_mag = p_rnd[MW-1:0];
	assign rnd     = p_neg ? -$signed(rnd_mag) : $signed(rnd_mag);

	assign avg_sum = (MW + 1)'(avg_q) + (MW + 1)'(rnd);
	assign ndb_sum = (MW + 1)'(needle_db_q) + (MW + 1)'(rnd);
	assign npw_sum = (MW + 1)'($signed({1'b0, needle_pw_q})) + (MW + 1)'(rnd);

	// Peak replacement tests
	assign db_age_over = CW'(held_db_age_q) > CW'(cfg.peak_hold_ticks);
	assign pw_age_over = CW'(held_pw_age_q) > CW'(cfg.peak_hold_ticks);
	assign db_replace  = (cal_level >= held_db_q) || !held_db_valid_q || db_age_over;
	assign pw_replace  = (fwd_q >= held_pw_q) || !held_pw_valid_q || pw_age_over;

	// S-unit and over-S9 readout from the displayed reading
	assign disp_x   = (DBW + 1)'(sel_db);
	assign over_sum = disp_x + DB_HALF;
	assign over_w   = over_sum >>> DB_FRAC_BITS;
	assign sun_num  = FLOOR_OFS + disp_x;
	assign sun_q    = (sun_num + SUNIT_RND) >>> DB_FRAC_BITS;
	assign sun_prod = 13'(sun_q[6:0]) * 13'd43;
	assign sun_raw  = sun_prod[12:8];

	always_comb begin
		kind = slm_pkg::RK_NONE;
		sun  = '0;
		over = '0;
		if (have_reading_q) begin
			if (disp_x >= DB_HALF) begin
				kind = slm_pkg::RK_OVER;
				sun  = 4'(slm_pkg::SUNIT_MAX);
				over = (over_w > OVER_LIM) ? 6'(slm_pkg::OVER_MAX) : over_w[5:0];
			end else begin
				kind = slm_pkg::RK_SUNIT;
				if (sun_num <= 0) begin
					sun = '0;
				end else if (sun_raw > 5'(slm_pkg::SUNIT_MAX)) begin
					sun = 4'(slm_pkg::SUNIT_MAX);
				end else begin
					sun = sun_raw[3:0];
				end
			end
		end
	end

	assign sel_x    = WX'(sel_db);
	assign needle_x = WX'(needle_db_q);
	assign held_x   = WX'(held_db_q);

	// Latch the request payload and the multiplier product
	always_ff @(posedge clk) begin
		if (cmd.load_item) begin
			raw_q <= raw_level;
			fwd_q <= forward_power;
		end
		if (cmd.avg_mul || cmd.ndb_mul || cmd.npw_mul) begin
			prod_q <= prod;
		end
	end

	// Meter state updates
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			level_q         <= '0;
			avg_q           <= '0;
			avg_started_q   <= 1'b0;
			have_reading_q  <= 1'b0;
			tx_q            <= 1'b0;
			held_db_q       <= DB_FLOOR;
			held_db_valid_q <= 1'b0;
			held_db_age_q   <= '0;
			needle_db_q     <= '0;
			fwd_power_q     <= '0;
			held_pw_q       <= '0;
			held_pw_valid_q <= 1'b0;
			held_pw_age_q   <= '0;
			needle_pw_q     <= '0;
		end else begin
			if (cmd.rx_load) begin
				tx_q           <= 1'b0;
				level_q        <= cal_level;
				have_reading_q <= 1'b1;
				if (db_replace) begin
					held_db_q       <= cal_level;
					held_db_valid_q <= 1'b1;
					held_db_age_q   <= '0;
				end
			end
			if (cmd.avg_add) begin
				avg_q         <= avg_started_q ? DBW'(avg_sum) : level_q;
				avg_started_q <= 1'b1;
			end
			if (cmd.tx_load) begin
				tx_q        <= 1'b1;
				fwd_power_q <= fwd_q;
				if (pw_replace) begin
					held_pw_q       <= fwd_q;
					held_pw_valid_q <= 1'b1;
					held_pw_age_q   <= '0;
				end
			end
			if (cmd.ndb_add) begin
				needle_db_q <= DBW'(ndb_sum);
			end
			if (cmd.npw_add) begin
				needle_pw_q <= npw_sum[10:0];
				// Age both peaks once per tick, saturating
				if (!(&held_db_age_q)) begin
					held_db_age_q <= held_db_age_q + 1'b1;
				end
				if (!(&held_pw_age_q)) begin
					held_pw_age_q <= held_pw_age_q + 1'b1;
				end
			end
		end
	end

	// Result register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.emit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// Result register payload
	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			out_display_db   <= sel_x[10:0];
			out_needle_db    <= needle_x[10:0];
			out_peak_db      <= held_x[10:0];
			out_readout_kind <= kind;
			out_s_unit       <= sun;
			out_over_s9_db   <= over;
			out_needle_power <= needle_pw_q;
			out_peak_power   <= held_pw_q;
			out_transmitting <= tx_q;
		end
	end

	assign out_valid    = out_valid_q;
	assign sts.out_free = !out_valid_q || out_ready;

	a_emit_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |-> (!out_valid_q || out_ready))
		else $error("result loaded over an untaken result");

	a_peak_stays_valid: assert property (@(posedge clk) disable iff (!arst_n)
		held_db_valid_q |=> held_db_valid_q)
		else $error("dB peak lost its valid flag");

	a_avg_started: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.avg_add |=> (avg_started_q && have_reading_q))
		else $error("average updated without a reading");

endmodule

`default_nettype wire

// File: rtl/signal_level_meter.sv
// ----------------------------------------------------------------------------
// signal_level_meter
// S-meter with calibration lookup, exponential average, timed peak hold,
// forward power peak and asymmetric needle smoothing on frame ticks.
// ----------------------------------------------------------------------------
//  Channel  | Direction | Payload                                   | Rate
//  sample   | in        | action, raw_level, forward_power          | 1 per item
//  result   | out       | readings, needles, peaks, S-unit readout  | 1 per item
//  cfg      | in        | index (3 bits), data (16 bits)            | every cycle
//
//  A receive sample smooths the average, a frame tick smooths both needles;
//  a transmit sample and an unused action need no smoothing. The shared
//  smoothing multiplier and its rounding adder work in turn on each quantity.
//  The result register holds one result while the next request is taken.
//  arst_n clears all meter state and loads register reset values at once.
//  A stalled result holds the sequencer in its final step; cfg is never held.
// ----------------------------------------------------------------------------
`default_nettype none

module signal_level_meter #(
	parameter int DB_FRAC_BITS = 4,
	parameter int AGE_BITS     = 8
) (
	input  wire logic clk,
	input  wire logic arst_n,
	slm_item_if.sink     sample,
	slm_result_if.source result,
	slm_cfg_if.sink      cfg
);

	slm_pkg::cfg_t cfg_val;
	slm_pkg::cmd_t cmd;
	slm_pkg::sts_t sts;

	// Configuration registers
	slm_cfg_regs u_cfg (
		.clk    (clk),
		.arst_n (arst_n),
		.wr     (cfg),
		.cfg    (cfg_val)
	);

	// Sequencer
	slm_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (sample.valid),
		.in_action (sample.action),
		.in_ready  (sample.ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	// Meter datapath and result register
	slm_datapath #(
		.DB_FRAC_BITS (DB_FRAC_BITS),
		.AGE_BITS     (AGE_BITS)
	) u_dp (
		.clk              (clk),
		.arst_n           (arst_n),
		.cmd              (cmd),
		.sts              (sts),
		.cfg              (cfg_val),
		.raw_level        (sample.raw_level),
		.forward_power    (sample.forward_power),
		.out_valid        (result.valid),
		.out_ready        (result.ready),
		.out_display_db   (result.display_db),
		.out_needle_db    (result.needle_db),
		.out_peak_db      (result.peak_db),
		.out_readout_kind (result.readout_kind),
		.out_s_unit       (result.s_unit),
		.out_over_s9_db   (result.over_s9_db),
		.out_needle_power (result.needle_power),
		.out_peak_power   (result.peak_power),
		.out_transmitting (result.transmitting)
	);

endmodule

`default_nettype wire

// File: tb/sv/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for signal_level_meter. A directed stimulus table is
// followed by phases of random receive, transmit, frame tick and unused
// requests under different register settings and idle patterns. Every result
// is checked field by field against a pinned reading or the bench's meter model.
// ----------------------------------------------------------------------------
`default_nettype none

module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	import slm_pkg::*;

	localparam int DB_ONE          = 16;
	localparam int DB_FLOOR        = -54 * DB_ONE;
	localparam int AGE_TOP         = 255;
	localparam int KNEES           = 14;
	localparam int RUN_LIMIT       = 400000;
	localparam int PRESSURE_CYCLES = 300;
	localparam int DRAIN_CYCLES    = 12;
	localparam int PHASE_ITEMS     = 255;
	localparam int PHASES          = 6;

	// Calibration knees: raw strength against whole dB relative to S9
	localparam int KNEE_RAW [KNEES] = '{10, 24, 38, 47, 61, 70, 79, 84, 94, 103, 118, 134,
		147, 161};
	localparam int KNEE_DB [KNEES] = '{-48, -42, -36, -30, -24, -18, -12, -6, 0, 10, 20, 30,
		40, 50};

	typedef struct packed {
		logic signed [10:0] display_db;
		logic signed [10:0] needle_db;
		logic signed [10:0] peak_db;
		readout_kind_t      readout_kind;
		logic [3:0]         s_unit;
		logic [5:0]         over_s9_db;
		logic [10:0]        needle_power;
		logic [10:0]        peak_power;
		logic               transmitting;
	} meter_reading_t;

	typedef struct packed {
		action_t        act;
		logic [7:0]     raw;
		logic [10:0]    fwd;
		logic           pinned;
		meter_reading_t want;
	} primer_row_t;

	localparam meter_reading_t NO_PIN = '0;
	localparam int PRIMER_LEN = 25;

	// Directed requests; pinned rows carry a reading known from reset values
	localparam primer_row_t PRIMER [PRIMER_LEN] = '{
		'{ACT_NONE, 8'd0,   11'd0,    1'b1, '{11'sd0, 11'sd0, -11'sd864, RK_NONE, 4'd0, 6'd0,
			11'd0, 11'd0, 1'b0}},
		'{ACT_RX,   8'd0,   11'd0,    1'b1, '{-11'sd768, 11'sd0, -11'sd768, RK_SUNIT, 4'd1,
			6'd0, 11'd0, 11'd0, 1'b0}},
		'{ACT_RX,   8'd255, 11'd0,    1'b1, '{11'sd800, 11'sd0, 11'sd800, RK_OVER, 4'd9,
			6'd50, 11'd0, 11'd0, 1'b0}},
		'{ACT_TX,   8'd0,   11'd2047, 1'b1, '{11'sd800, 11'sd0, 11'sd800, RK_OVER, 4'd9,
			6'd50, 11'd0, 11'd2047, 1'b1}},
		'{ACT_TX,   8'd0,   11'd0,    1'b1, '{11'sd800, 11'sd0, 11'sd800, RK_OVER, 4'd9,
			6'd50, 11'd0, 11'd2047, 1'b1}},
		'{ACT_NONE, 8'd255, 11'd2047, 1'b1, '{11'sd800, 11'sd0, 11'sd800, RK_OVER, 4'd9,
			6'd50, 11'd0, 11'd2047, 1'b1}},
		'{ACT_TICK, 8'd0,   11'd0,    1'b0, NO_PIN},
		'{ACT_TX,   8'd0,   11'd1500, 1'b0, NO_PIN},
		'{ACT_TICK, 8'd0,   11'd0,    1'b0, NO_PIN},
		'{ACT_RX,   8'd10,  11'd0,    1'b0, NO_PIN},
		'{ACT_RX,   8'd11,  11'd0,    1'b0, NO_PIN},
		'{ACT_RX,   8'd160, 11'd0,    1'b0, NO_PIN},
		'{ACT_RX,   8'd161, 11'd0,    1'b0, NO_PIN},
		'{ACT_RX,   8'd94,  11'd0,    1'b0, NO_PIN},
		'{ACT_RX,   8'd95,  11'd0,    1'b0, NO_PIN},
		'{ACT_RX,   8'd84,  11'd0,    1'b0, NO_PIN},
		'{ACT_TICK, 8'd0,   11'd0,    1'b0, NO_PIN},
		'{ACT_RX,   8'd47,  11'd0,    1'b0, NO_PIN},
		'{ACT_RX,   8'd24,  11'd0,    1'b0, NO_PIN},
		'{ACT_TICK, 8'd0,   11'd0,    1'b0, NO_PIN},
		'{ACT_TX,   8'd0,   11'd1024, 1'b0, NO_PIN},
		'{ACT_TICK, 8'd0,   11'd0,    1'b0, NO_PIN},
		'{ACT_TX,   8'd0,   11'd1023, 1'b0, NO_PIN},
		'{ACT_RX,   8'd128, 11'd0,    1'b0, NO_PIN},
		'{ACT_NONE, 8'd170, 11'd1365, 1'b0, NO_PIN}
	};

	logic clk;
	logic arst_n;

	slm_item_if   sample_ch ();
	slm_result_if result_ch ();
	slm_cfg_if    cfg_ch ();

	signal_level_meter i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.sample (sample_ch),
		.result (result_ch),
		.cfg    (cfg_ch)
	);

	// Meter model state, starting at its reset values
	int         inst_db     = 0;
	int         avg_db      = 0;
	bit         avg_live    = 1'b0;
	bit         heard       = 1'b0;
	bit         keying      = 1'b0;
	int         pk_db       = DB_FLOOR;
	bit         pk_db_live  = 1'b0;
	int         pk_db_age   = 0;
	int         needle_pos  = 0;
	int         fwd_pw      = 0;
	int         pk_pw       = 0;
	bit         pk_pw_live  = 1'b0;
	int         pk_pw_age   = 0;
	int         needle_pw   = 0;

	disp_mode_t cfg_mode    = DISP_INST;
	int         cfg_hold    = 45;
	int         cfg_avg     = 19661;
	int         cfg_db_up   = 21627;
	int         cfg_db_down = 3604;
	int         cfg_pw_up   = 27034;
	int         cfg_pw_down = 6179;

	meter_reading_t readings_due [$];

	logic           pin_now;
	meter_reading_t pin_reading;
	logic           hold_back;
	bit             pressure_go = 1'b0;
	int             send_idle_pct = 0;
	int             recv_idle_pct = 0;
	int             n_sent = 0;
	int             n_results = 0;
	int             n_rx = 0;
	int             n_tx = 0;
	int             n_tick = 0;
	int             n_unused = 0;
	int             mismatches = 0;
	int unsigned    cycles_run = 0;

	// Divide a Q16 product by 65536, rounding ties away from zero
	function automatic int q16_round(longint p);
		if (p >= 0) begin
			return int'((p + 32768) >>> 16);
		end
		return -int'(((-p) + 32768) >>> 16);
	endfunction

	// One step of asymmetric first-order smoothing
	function automatic int glide(int cur, int target, int up, int down);
		int c;
		c = (target > cur) ? up : down;
		return cur + q16_round(longint'(target - cur) * longint'(c));
	endfunction

	// Map raw strength to dB/16 by linear interpolation between knees
	function automatic int raw_to_db16(int raw);
		int i;
		int span;
		int num;
		if (raw <= KNEE_RAW[0]) begin
			return KNEE_DB[0] * DB_ONE;
		end
		if (raw >= KNEE_RAW[KNEES-1]) begin
			return KNEE_DB[KNEES-1] * DB_ONE;
		end
		for (i = 1; i < KNEES; i++) begin
			if (raw <= KNEE_RAW[i]) begin
				span = KNEE_RAW[i] - KNEE_RAW[i-1];
				num = (raw - KNEE_RAW[i-1]) * (KNEE_DB[i] - KNEE_DB[i-1]) * DB_ONE;
				return KNEE_DB[i-1] * DB_ONE + (2 * num + span) / (2 * span);
			end
		end
		return KNEE_DB[KNEES-1] * DB_ONE;
	endfunction

	function automatic int shown_db();
		case (cfg_mode)
			DISP_AVG:  return avg_db;
			DISP_PEAK: return pk_db;
			default:   return inst_db;
		endcase
	endfunction

	function automatic void meter_write_reg(cfg_index_t idx, logic [15:0] d);
		case (idx)
			CFG_DISPLAY_MODE: cfg_mode = disp_mode_t'(d[1:0]);
			CFG_PEAK_HOLD:    cfg_hold = int'(d[7:0]);
			CFG_AVERAGE_COEF: cfg_avg = int'(d);
			CFG_DB_ATTACK:    cfg_db_up = int'(d);
			CFG_DB_DECAY:     cfg_db_down = int'(d);
			CFG_POWER_ATTACK: cfg_pw_up = int'(d);
			CFG_POWER_DECAY:  cfg_pw_down = int'(d);
			default: ;
		endcase
	endfunction

	// Apply one request to the meter model and return the reading it shows
	function automatic meter_reading_t advance_meter(action_t act, logic [7:0] raw,
		logic [10:0] fwd);
		meter_reading_t r;
		int disp;
		int num;
		int su;
		int over;
		case (act)
			ACT_RX: begin
				keying = 1'b0;
				inst_db = raw_to_db16(int'(raw));
				heard = 1'b1;
				if (!avg_live) begin
					avg_db = inst_db;
					avg_live = 1'b1;
				end else begin
					avg_db += q16_round(longint'(inst_db - avg_db) * longint'(cfg_avg));
				end
				if (inst_db >= pk_db || !pk_db_live || pk_db_age > cfg_hold) begin
					pk_db = inst_db;
					pk_db_live = 1'b1;
					pk_db_age = 0;
				end
			end
			ACT_TX: begin
				keying = 1'b1;
				fwd_pw = int'(fwd);
				if (fwd_pw >= pk_pw || !pk_pw_live || pk_pw_age > cfg_hold) begin
					pk_pw = fwd_pw;
					pk_pw_live = 1'b1;
					pk_pw_age = 0;
				end
			end
			ACT_TICK: begin
				needle_pos = glide(needle_pos, heard ? shown_db() : DB_FLOOR, cfg_db_up,
					cfg_db_down);
				needle_pw = glide(needle_pw, keying ? fwd_pw : 0, cfg_pw_up, cfg_pw_down);
				if (pk_db_age < AGE_TOP) begin
					pk_db_age++;
				end
				if (pk_pw_age < AGE_TOP) begin
					pk_pw_age++;
				end
			end
			default: ;
		endcase

		disp = shown_db();
		r = '0;
		r.readout_kind = RK_NONE;
		if (heard) begin
			if (disp >= DB_ONE / 2) begin
				over = (disp + DB_ONE / 2) / DB_ONE;
				r.readout_kind = RK_OVER;
				r.s_unit = 4'd9;
				r.over_s9_db = (over > 60) ? 6'd60 : over[5:0];
			end else begin
				num = 54 * DB_ONE + disp;
				su = (num <= 0) ? 0 : (2 * num + 6 * DB_ONE) / (12 * DB_ONE);
				r.readout_kind = RK_SUNIT;
				r.s_unit = (su > 9) ? 4'd9 : su[3:0];
			end
		end
		r.display_db = disp[10:0];
		r.needle_db = needle_pos[10:0];
		r.peak_db = pk_db[10:0];
		r.needle_power = needle_pw[10:0];
		r.peak_power = pk_pw[10:0];
		r.transmitting = keying;
		return r;
	endfunction

	task automatic flag_mismatch(string field, int got, int want);
		if (mismatches < 40) begin
			$display("result %0d: %s is %0d, expected %0d", n_results, field, got, want);
		end
		mismatches++;
	endtask

	task automatic compare_reading(meter_reading_t got, meter_reading_t want);
		if (got.display_db !== want.display_db) begin
			flag_mismatch("display_db", $signed(got.display_db), $signed(want.display_db));
		end
		if (got.needle_db !== want.needle_db) begin
			flag_mismatch("needle_db", $signed(got.needle_db), $signed(want.needle_db));
		end
		if (got.peak_db !== want.peak_db) begin
			flag_mismatch("peak_db", $signed(got.peak_db), $signed(want.peak_db));
		end
		if (got.readout_kind !== want.readout_kind) begin
			flag_mismatch("readout_kind", int'(got.readout_kind), int'(want.readout_kind));
		end
		if (got.s_unit !== want.s_unit) begin
			flag_mismatch("s_unit", int'(got.s_unit), int'(want.s_unit));
		end
		if (got.over_s9_db !== want.over_s9_db) begin
			flag_mismatch("over_s9_db", int'(got.over_s9_db), int'(want.over_s9_db));
		end
		if (got.needle_power !== want.needle_power) begin
			flag_mismatch("needle_power", int'(got.needle_power), int'(want.needle_power));
		end
		if (got.peak_power !== want.peak_power) begin
			flag_mismatch("peak_power", int'(got.peak_power), int'(want.peak_power));
		end
		if (got.transmitting !== want.transmitting) begin
			flag_mismatch("transmitting", int'(got.transmitting), int'(want.transmitting));
		end
	endtask

	// Clock
	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// Abort a hung run
	always @(posedge clk) begin
		cycles_run <= cycles_run + 1;
		if (cycles_run >= RUN_LIMIT) begin
			$display("run stopped after %0d cycles with %0d results outstanding", cycles_run,
				n_sent - n_results);
			$display("FAILURE");
			$finish;
		end
	end

	// Result side: random stalls, forced off during the pressure window
	initial begin
		result_ch.ready = 1'b0;
		hold_back = 1'b0;
	end

	always @(posedge clk) begin
		result_ch.ready <= !hold_back && ($urandom_range(0, 99) >= recv_idle_pct);
	end

	// Hold off the result side long enough to fill the block
	initial begin
		wait (pressure_go);
		@(posedge clk);
		hold_back <= 1'b1;
		repeat (PRESSURE_CYCLES) @(posedge clk);
		hold_back <= 1'b0;
	end

	// Track register writes and requests, check every result
	always @(posedge clk) begin
		meter_reading_t want;
		meter_reading_t seen;
		if (arst_n) begin
			if (cfg_ch.valid && cfg_ch.ready) begin
				meter_write_reg(cfg_index_t'(cfg_ch.index), cfg_ch.data);
			end
			if (sample_ch.valid && sample_ch.ready) begin
				want = advance_meter(action_t'(sample_ch.action), sample_ch.raw_level,
					sample_ch.forward_power);
				readings_due.push_back(pin_now ? pin_reading : want);
				case (action_t'(sample_ch.action))
					ACT_RX:   n_rx++;
					ACT_TX:   n_tx++;
					ACT_TICK: n_tick++;
					default:  n_unused++;
				endcase
			end
			if (result_ch.valid && result_ch.ready) begin
				seen.display_db = result_ch.display_db;
				seen.needle_db = result_ch.needle_db;
				seen.peak_db = result_ch.peak_db;
				seen.readout_kind = readout_kind_t'(result_ch.readout_kind);
				seen.s_unit = result_ch.s_unit;
				seen.over_s9_db = result_ch.over_s9_db;
				seen.needle_power = result_ch.needle_power;
				seen.peak_power = result_ch.peak_power;
				seen.transmitting = result_ch.transmitting;
				if (readings_due.size() == 0) begin
					flag_mismatch("unrequested result", 1, 0);
				end else begin
					compare_reading(seen, readings_due.pop_front());
				end
				n_results++;
			end
		end
	end

	// Offer one request, with random idle cycles ahead of it
	task automatic offer(action_t act, logic [7:0] raw, logic [10:0] fwd, logic pinned,
		meter_reading_t want);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			sample_ch.valid <= 1'b0;
			@(posedge clk);
		end
		sample_ch.valid <= 1'b1;
		sample_ch.action <= act;
		sample_ch.raw_level <= raw;
		sample_ch.forward_power <= fwd;
		pin_now <= pinned;
		pin_reading <= want;
		@(posedge clk);
		while (!sample_ch.ready) @(posedge clk);
		n_sent++;
	endtask

	// Stop offering and wait until every result has come back
	task automatic drain();
		sample_ch.valid <= 1'b0;
		while (n_results < n_sent) @(posedge clk);
	endtask

	task automatic write_reg(cfg_index_t idx, logic [15:0] val);
		cfg_ch.valid <= 1'b1;
		cfg_ch.index <= idx;
		cfg_ch.data <= val;
		@(posedge clk);
		while (!cfg_ch.ready) @(posedge clk);
	endtask

	// Write all registers; unused data bits get random values
	task automatic program_meter(disp_mode_t mode, logic [7:0] hold, logic [15:0] avg,
		logic [15:0] db_up, logic [15:0] db_down, logic [15:0] pw_up, logic [15:0] pw_down);
		logic [15:0] pad;
		pad = 16'($urandom);
		write_reg(CFG_DISPLAY_MODE, {pad[15:2], mode});
		write_reg(CFG_PEAK_HOLD, {pad[15:8], hold});
		write_reg(CFG_AVERAGE_COEF, avg);
		write_reg(CFG_DB_ATTACK, db_up);
		write_reg(CFG_DB_DECAY, db_down);
		write_reg(CFG_POWER_ATTACK, pw_up);
		write_reg(CFG_POWER_DECAY, pw_down);
		cfg_ch.valid <= 1'b0;
	endtask

	// Random mix of samples, ticks and tick bursts that let peaks expire
	task automatic run_traffic(int count, int hold);
		int left;
		int pick;
		int burst;
		int cap;
		logic [7:0] raw;
		logic [10:0] fwd;
		left = count;
		cap = (hold + 3 > 40) ? 40 : hold + 3;
		while (left > 0) begin
			pick = $urandom_range(0, 99);
			raw = ($urandom_range(0, 3) == 0) ?
				8'(KNEE_RAW[$urandom_range(0, KNEES - 1)] + $urandom_range(0, 2) - 1) :
				8'($urandom_range(0, 255));
			fwd = ($urandom_range(0, 7) == 0) ? ($urandom_range(0, 1) ? 11'd2047 : 11'd0) :
				11'($urandom_range(0, 2047));
			if (pick < 4) begin
				burst = $urandom_range(1, cap);
				repeat (burst) offer(ACT_TICK, raw, fwd, 1'b0, NO_PIN);
				left -= burst;
			end else begin
				if (pick < 8) begin
					offer(ACT_NONE, raw, fwd, 1'b0, NO_PIN);
				end else if (pick < 48) begin
					offer(ACT_RX, raw, fwd, 1'b0, NO_PIN);
				end else if (pick < 68) begin
					offer(ACT_TX, raw, fwd, 1'b0, NO_PIN);
				end else begin
					offer(ACT_TICK, raw, fwd, 1'b0, NO_PIN);
				end
				left--;
			end
		end
	endtask

	// Stimulus
	initial begin
		int phase;
		int hold;
		arst_n = 1'b0;
		sample_ch.valid = 1'b0;
		sample_ch.action = ACT_RX;
		sample_ch.raw_level = 8'd0;
		sample_ch.forward_power = 11'd0;
		cfg_ch.valid = 1'b0;
		cfg_ch.index = CFG_DISPLAY_MODE;
		cfg_ch.data = 16'd0;
		pin_now = 1'b0;
		pin_reading = NO_PIN;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		// Directed table under reset register values
		send_idle_pct = 20;
		recv_idle_pct = 58;
		for (int k = 0; k < PRIMER_LEN; k++) begin
			offer(PRIMER[k].act, PRIMER[k].raw, PRIMER[k].fwd, PRIMER[k].pinned,
				PRIMER[k].want);
		end
		drain();

		for (phase = 0; phase < PHASES; phase++) begin
			if (phase < 2) begin
				send_idle_pct = 20;
				recv_idle_pct = 58;
			end else if (phase < 4) begin
				send_idle_pct = 58;
				recv_idle_pct = 20;
			end else begin
				send_idle_pct = 0;
				recv_idle_pct = 0;
			end

			case (phase)
				0: begin
					hold = 1;
					program_meter(DISP_AVG, 8'd1, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF,
						16'hFFFF);
					// the spare index must leave every register alone
					write_reg(CFG_UNUSED, 16'($urandom));
					cfg_ch.valid <= 1'b0;
				end
				1: begin
					hold = 0;
					program_meter(DISP_PEAK, 8'd0, 16'h0000, 16'h0000, 16'h0000, 16'h0000,
						16'h0000);
				end
				2: begin
					hold = 255;
					program_meter(DISP_RSVD, 8'd255, 16'($urandom), 16'($urandom),
						16'($urandom), 16'($urandom), 16'($urandom));
				end
				3: begin
					hold = $urandom_range(1, 8);
					program_meter(DISP_PEAK, 8'(hold), 16'($urandom), 16'($urandom),
						16'($urandom), 16'($urandom), 16'($urandom));
				end
				4: begin
					hold = $urandom_range(0, 40);
					program_meter(DISP_AVG, 8'(hold), 16'($urandom), 16'($urandom),
						16'($urandom), 16'($urandom), 16'($urandom));
				end
				default: begin
					hold = $urandom_range(0, 255);
					program_meter(DISP_INST, 8'(hold), 16'($urandom), 16'($urandom),
						16'($urandom), 16'($urandom), 16'($urandom));
				end
			endcase

			if (phase == 2) begin
				// strong peak, then enough ticks to saturate its age, then a weak sample
				offer(ACT_RX, 8'd255, 11'd0, 1'b0, NO_PIN);
				repeat (300) offer(ACT_TICK, 8'd0, 11'd0, 1'b0, NO_PIN);
				offer(ACT_RX, 8'd0, 11'd0, 1'b0, NO_PIN);
			end
			if (phase == 3) begin
				pressure_go = 1'b1;
			end
			run_traffic(PHASE_ITEMS, hold);
			drain();
		end

		repeat (DRAIN_CYCLES) @(posedge clk);
		$display("covered %0d requests: %0d receive, %0d transmit, %0d tick, %0d unused",
			n_sent, n_rx, n_tx, n_tick, n_unused);
		$display("%0d readings checked over %0d register settings, %0d mismatches",
			n_results, PHASES + 1, mismatches);
		if (mismatches == 0 && readings_due.size() == 0) begin
			$display("SUCCESS");
		end else begin
			$display("FAILURE");
		end
		$finish;
	end

endmodule

`default_nettype wire
